// ===== rtl/ffba_pkg.sv =====
// Shared types, codes and defaults for the first-fit block allocator.
// No dependencies.
package ffba_pkg;

    localparam int ARENA_BYTES_DEF  = 65536;
    localparam int HEADER_BYTES_DEF = 32;
    localparam int MAX_BLOCKS_DEF   = 1024;

    localparam logic [1:0] CMD_INIT  = 2'd0;
    localparam logic [1:0] CMD_ALLOC = 2'd1;
    localparam logic [1:0] CMD_FREE  = 2'd2;
    localparam logic [1:0] CMD_QUERY = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_SPACE  = 3'd1;
    localparam logic [2:0] ST_FREE_ALR  = 3'd2;
    localparam logic [2:0] ST_NOT_START = 3'd3;
    localparam logic [2:0] ST_RANGE     = 3'd4;

    // One row of the block table.
    typedef struct packed {
        logic        free;
        logic [15:0] size;
    } t_entry;

endpackage

// ===== rtl/first_fit_block_allocator.sv =====
// First-fit block allocator, top level: command sequencer around the block table.
// Depends on ffba_pkg and ffba_table.
//
//  channel  | ports                                        | transfer when
//  ---------+----------------------------------------------+-------------------
//  command  | start, busy, i_command, i_byte_count,        | start && !busy
//           | i_block_handle, i_block_index                |
//  result   | o_done, o_status, o_block_offset,            | o_done (one cycle)
//           | o_block_size, o_block_free                   |
//
// A command walks the table from row 0 until a hit or the end (no fit,
// no such header, index out of range). Init, and allocate on a full table, skip it.
// An allocate hit moves the rows behind it up one per cycle, then writes the used
// row and the remainder row. A free hit on a row already free reports that row;
// else it writes the merged row and, after a merge, moves any rows behind it down.
// Busy drops in the strobe cycle; init keeps it high in S_INIT while writing row 0,
// and after reset the block starts in S_INIT, writing row 0 with busy high.
// The result receiver cannot stall; each result is a one-cycle strobe.
module first_fit_block_allocator import ffba_pkg::*; #(
    parameter int ARENA_BYTES  = ARENA_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_byte_count,
    input  logic [15:0] i_block_handle,
    input  logic [9:0]  i_block_index,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [15:0] o_block_offset,
    output logic [15:0] o_block_size,
    output logic        o_block_free
);

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = AW + 1;
    localparam logic [16:0] HDR = 17'(HEADER_BYTES);
    localparam logic [15:0] INIT_SIZE = 16'(ARENA_BYTES - 2 * HEADER_BYTES);
    localparam logic [CW-1:0] FULL = CW'(MAX_BLOCKS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INIT  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_FNEXT = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_AW1   = 3'd5;
    localparam logic [2:0] S_AW2   = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [1:0]    r_cmd, n_cmd;
    logic [15:0]   r_req, n_req;
    logic [15:0]   r_handle, n_handle;
    logic [9:0]    r_idx, n_idx;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_k, n_k;
    logic [16:0]   r_off, n_off;
    t_entry        r_prev, n_prev;
    t_entry        r_hit, n_hit;
    logic          r_pf, n_pf;
    logic [1:0]    r_rm, n_rm;
    logic [AW-1:0] r_src, n_src;
    logic [AW-1:0] r_dst, n_dst;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_wv, n_wv;
    logic          r_up, n_up;
    logic          r_done, n_done;
    logic [2:0]    r_status, n_status;
    logic [15:0]   r_ooff, n_ooff;
    logic [15:0]   r_osize, n_osize;
    logic          r_ofree, n_ofree;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    t_entry        wdata, rdata;

    // Scratch values for the search and merge steps.
    logic          hit, nf;
    logic [16:0]   need, msz;
    logic [CW-1:0] mrg_idx;

    ffba_table #(.DEPTH(MAX_BLOCKS)) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_block_offset = r_ooff;
    assign o_block_size   = r_osize;
    assign o_block_free   = r_ofree;

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_req    = r_req;
        n_handle = r_handle;
        n_idx    = r_idx;
        n_count  = r_count;
        n_k      = r_k;
        n_off    = r_off;
        n_prev   = r_prev;
        n_hit    = r_hit;
        n_pf     = r_pf;
        n_rm     = r_rm;
        n_src    = r_src;
        n_dst    = r_dst;
        n_cnt    = r_cnt;
        n_wv     = r_wv;
        n_up     = r_up;
        n_done   = 1'b0;
        n_status = r_status;
        n_ooff   = r_ooff;
        n_osize  = r_osize;
        n_ofree  = r_ofree;
        we       = 1'b0;
        waddr    = '0;
        wdata    = '0;
        raddr    = '0;
        hit      = 1'b0;
        nf       = 1'b0;
        need     = {1'b0, r_req} + HDR;
        msz      = '0;
        mrg_idx  = r_k;

        case (r_state)
            S_IDLE: begin
                // Keep row 0 on the read port so a scan can start at once.
                raddr = '0;
                if (start) begin
                    n_cmd    = i_command;
                    n_req    = i_byte_count;
                    n_handle = i_block_handle;
                    n_idx    = i_block_index;
                    n_k      = '0;
                    n_off    = '0;
                    n_prev   = '0;
                    case (i_command)
                        CMD_INIT: begin
                            n_done   = 1'b1;
                            n_status = ST_OK;
                            n_ooff   = '0;
                            n_osize  = INIT_SIZE;
                            n_ofree  = 1'b1;
                            n_state  = S_INIT;
                        end
                        CMD_ALLOC: begin
                            if (r_count == FULL) begin
                                // Table full: refuse, leave the state alone.
                                n_done   = 1'b1;
                                n_status = ST_NO_SPACE;
                                n_ooff   = '0;
                                n_osize  = '0;
                                n_ofree  = 1'b0;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: n_state = S_SCAN;
                    endcase
                end
            end
            S_INIT: begin
                we      = 1'b1;
                waddr   = '0;
                wdata   = '{free: 1'b1, size: INIT_SIZE};
                n_count = CW'(1);
                n_state = S_IDLE;
            end
            S_SCAN: begin
                // rdata holds row r_k; fetch the row behind it.
                raddr = AW'(r_k + CW'(1));
                if (r_k == r_count) begin
                    n_done  = 1'b1;
                    n_ooff  = '0;
                    n_osize = '0;
                    n_ofree = 1'b0;
                    case (r_cmd)
                        CMD_ALLOC: n_status = ST_NO_SPACE;
                        CMD_FREE:  n_status = ST_NOT_START;
                        default:   n_status = ST_RANGE;
                    endcase
                    n_state = S_IDLE;
                end else begin
                    case (r_cmd)
                        CMD_ALLOC: hit = rdata.free && ({1'b0, rdata.size} >= need);
                        CMD_FREE:  hit = (r_off == {1'b0, r_handle});
                        default:   hit = (32'(r_k) == 32'(r_idx));
                    endcase
                    if (hit) begin
                        n_hit = rdata;
                        case (r_cmd)
                            CMD_ALLOC: begin
                                n_status = ST_OK;
                                n_ooff   = r_off[15:0];
                                n_osize  = r_req;
                                n_ofree  = 1'b0;
                                // Open a row at r_k+1: move rows behind it up one.
                                n_src   = AW'(r_count - CW'(1));
                                n_dst   = AW'(r_count);
                                n_cnt   = r_count - CW'(1) - r_k;
                                n_up    = 1'b0;
                                n_wv    = 1'b0;
                                n_state = S_SHIFT;
                            end
                            CMD_FREE: begin
                                if (rdata.free) begin
                                    n_done   = 1'b1;
                                    n_status = ST_FREE_ALR;
                                    n_ooff   = r_off[15:0];
                                    n_osize  = rdata.size;
                                    n_ofree  = 1'b1;
                                    n_state  = S_IDLE;
                                end else begin
                                    n_pf    = (r_k != '0) && r_prev.free;
                                    n_state = S_FNEXT;
                                end
                            end
                            default: begin
                                n_done   = 1'b1;
                                n_status = ST_OK;
                                n_ooff   = r_off[15:0];
                                n_osize  = rdata.size;
                                n_ofree  = rdata.free;
                                n_state  = S_IDLE;
                            end
                        endcase
                    end else begin
                        n_prev = rdata;
                        n_off  = r_off + HDR + {1'b0, rdata.size};
                        n_k    = r_k + CW'(1);
                    end
                end
            end
            S_FNEXT: begin
                // rdata now holds the row after the freed block.
                nf    = ((r_k + CW'(1)) < r_count) && rdata.free;
                msz   = r_pf ? ({1'b0, r_prev.size} + HDR + {1'b0, r_hit.size})
                             : {1'b0, r_hit.size};
                if (nf) begin
                    msz = msz + HDR + {1'b0, rdata.size};
                end
                mrg_idx = r_pf ? (r_k - CW'(1)) : r_k;
                we    = 1'b1;
                waddr = AW'(mrg_idx);
                wdata = '{free: 1'b1, size: msz[15:0]};
                n_status = ST_OK;
                n_ooff   = r_pf ? 16'(r_off - HDR - {1'b0, r_prev.size}) : r_off[15:0];
                n_osize  = msz[15:0];
                n_ofree  = 1'b1;
                n_rm     = {1'b0, r_pf} + {1'b0, nf};
                if (!r_pf && !nf) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    // Close the gap: move rows behind the merge down.
                    n_src   = AW'(mrg_idx + CW'(1) + CW'(n_rm));
                    n_dst   = AW'(mrg_idx + CW'(1));
                    n_cnt   = r_count - CW'(1) - mrg_idx - CW'(n_rm);
                    n_up    = 1'b1;
                    n_wv    = 1'b0;
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                raddr = r_src;
                if (r_wv) begin
                    we    = 1'b1;
                    waddr = r_dst;
                    wdata = rdata;
                    n_dst = r_up ? (r_dst + AW'(1)) : (r_dst - AW'(1));
                end
                if (r_cnt != '0) begin
                    n_src = r_up ? (r_src + AW'(1)) : (r_src - AW'(1));
                    n_cnt = r_cnt - CW'(1);
                    n_wv  = 1'b1;
                end else begin
                    n_wv = 1'b0;
                    if (!r_wv) begin
                        if (r_cmd == CMD_ALLOC) begin
                            n_state = S_AW1;
                        end else begin
                            n_count = r_count - CW'(r_rm);
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_AW1: begin
                we      = 1'b1;
                waddr   = AW'(r_k);
                wdata   = '{free: 1'b0, size: r_req};
                n_state = S_AW2;
            end
            S_AW2: begin
                // Remainder row, kept even at size zero.
                we      = 1'b1;
                waddr   = AW'(r_k + CW'(1));
                wdata   = '{free: 1'b1, size: 16'({1'b0, r_hit.size} - need)};
                n_count = r_count + CW'(1);
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_count <= CW'(1);
            r_done  <= 1'b0;
            r_wv    <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
            r_wv    <= n_wv;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_req    <= n_req;
        r_handle <= n_handle;
        r_idx    <= n_idx;
        r_k      <= n_k;
        r_off    <= n_off;
        r_prev   <= n_prev;
        r_hit    <= n_hit;
        r_pf     <= n_pf;
        r_rm     <= n_rm;
        r_src    <= n_src;
        r_dst    <= n_dst;
        r_up     <= n_up;
        r_status <= n_status;
        r_ooff   <= n_ooff;
        r_osize  <= n_osize;
        r_ofree  <= n_ofree;
    end

    // Block count stays within the table.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= FULL))
        else $error("block count out of range");

    // Init is answered in the cycle after its transfer.
    a_init_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command == CMD_INIT)) |=> (o_done && (o_status == ST_OK)))
        else $error("init result missing");

    // Failed commands other than already-free report an empty block.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ST_OK) && (o_status != ST_FREE_ALR))
            |-> ((o_block_offset == '0) && (o_block_size == '0) && !o_block_free))
        else $error("failed result not zero");

    // No result while a table shift is still moving rows.
    a_shift_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) && (r_wv || (r_cnt != '0)) |=> !o_done)
        else $error("result during shift");

endmodule

// ===== rtl/ffba_table.sv =====
// Block table storage: one write port, one read port with registered data.
// Depends on ffba_pkg.
module ffba_table import ffba_pkg::*; #(
    parameter int DEPTH = MAX_BLOCKS_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sim/first_fit_block_allocator_tb.sv =====
// Self-checking testbench for first_fit_block_allocator: directed table, then random traffic.
// Holds its own table-level predictor of the allocator. Depends on ffba_pkg and the RTL.
`timescale 1ns / 100ps

module first_fit_block_allocator_tb;
    import ffba_pkg::*;

    localparam int ARENA  = ARENA_BYTES_DEF;
    localparam int HDR    = HEADER_BYTES_DEF;
    localparam int NBLK   = MAX_BLOCKS_DEF;
    localparam int RANDOM_OPS = 550;
    // A command walks and shifts the whole table at worst.
    localparam int DRAIN_CYCLES = 2 * NBLK + 64;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] offset;
        logic [15:0] size;
        logic        free;
    } t_alloc_result;

    typedef struct {
        logic [1:0]    cmd;
        logic [15:0]   count;
        logic [15:0]   handle;
        logic [9:0]    index;
        bit            typed;
        t_alloc_result want;
    } t_cmd_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_command = CMD_QUERY;
    logic [15:0] i_byte_count = '0;
    logic [15:0] i_block_handle = '0;
    logic [9:0]  i_block_index = '0;
    logic        o_done;
    logic [2:0]  o_status;
    logic [15:0] o_block_offset;
    logic [15:0] o_block_size;
    logic        o_block_free;

    first_fit_block_allocator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_command(i_command), .i_byte_count(i_byte_count),
        .i_block_handle(i_block_handle), .i_block_index(i_block_index),
        .o_done(o_done), .o_status(o_status), .o_block_offset(o_block_offset),
        .o_block_size(o_block_size), .o_block_free(o_block_free)
    );

    always #6 i_clk = ~i_clk;

    // Predictor copy of the block table.
    int unsigned   blk_size[NBLK];
    bit            blk_free[NBLK];
    int            blk_count;

    t_alloc_result pending_results[$];
    int            mismatches = 0;
    bit            no_idle = 1'b0;

    function automatic t_alloc_result pack_result(logic [2:0] st, int unsigned off,
                                                  int unsigned sz, bit fr);
        t_alloc_result r;
        r.status = st;
        r.offset = off[15:0];
        r.size   = sz[15:0];
        r.free   = fr;
        return r;
    endfunction

    function automatic int unsigned header_at(int p);
        int unsigned off;
        off = 0;
        for (int k = 0; k < p && k < blk_count; k++) off += HDR + blk_size[k];
        return off;
    endfunction

    function automatic void table_clear();
        blk_size[0] = ARENA - 2 * HDR;
        blk_free[0] = 1'b1;
        blk_count   = 1;
    endfunction

    function automatic void drop_row(int p);
        for (int k = p; k + 1 < blk_count; k++) begin
            blk_size[k] = blk_size[k + 1];
            blk_free[k] = blk_free[k + 1];
        end
        blk_count--;
    endfunction

    // Apply one command to the table copy and return the result it must produce.
    function automatic t_alloc_result allocator_step(logic [1:0] cmd, logic [15:0] cnt,
                                                     logic [15:0] hdl, logic [9:0] idx);
        int unsigned off;
        int unsigned need;
        int k;
        off = 0;
        case (cmd)
            CMD_INIT: begin
                table_clear();
                return pack_result(ST_OK, 0, blk_size[0], 1'b1);
            end
            CMD_ALLOC: begin
                need = cnt + HDR;
                for (k = 0; k < blk_count; k++) begin
                    if (blk_free[k] && blk_size[k] >= need) begin
                        if (blk_count >= NBLK) return pack_result(ST_NO_SPACE, 0, 0, 1'b0);
                        for (int j = blk_count; j > k + 1; j--) begin
                            blk_size[j] = blk_size[j - 1];
                            blk_free[j] = blk_free[j - 1];
                        end
                        blk_count++;
                        blk_size[k + 1] = blk_size[k] - need;
                        blk_free[k + 1] = 1'b1;
                        blk_size[k] = cnt;
                        blk_free[k] = 1'b0;
                        return pack_result(ST_OK, off, cnt, 1'b0);
                    end
                    off += HDR + blk_size[k];
                end
                return pack_result(ST_NO_SPACE, 0, 0, 1'b0);
            end
            CMD_FREE: begin
                for (k = 0; k < blk_count; k++) begin
                    if (off == hdl) break;
                    off += HDR + blk_size[k];
                end
                if (k >= blk_count) return pack_result(ST_NOT_START, 0, 0, 1'b0);
                if (blk_free[k]) return pack_result(ST_FREE_ALR, off, blk_size[k], 1'b1);
                if (k > 0 && blk_free[k - 1]) begin
                    blk_size[k - 1] += HDR + blk_size[k];
                    drop_row(k);
                    k--;
                end
                if (k + 1 < blk_count && blk_free[k + 1]) begin
                    blk_size[k] += HDR + blk_size[k + 1];
                    drop_row(k + 1);
                end
                blk_free[k] = 1'b1;
                return pack_result(ST_OK, header_at(k), blk_size[k], 1'b1);
            end
            default: begin
                if (idx >= blk_count) return pack_result(ST_RANGE, 0, 0, 1'b0);
                return pack_result(ST_OK, header_at(idx), blk_size[idx], blk_free[idx]);
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Drive one command and hold it until the transfer; start stays high afterward
    // so back-to-back commands need no second assignment in the same step.
    task automatic issue(logic [1:0] cmd, logic [15:0] cnt, logic [15:0] hdl,
                         logic [9:0] idx, bit typed, t_alloc_result want);
        t_alloc_result pred;
        if (!no_idle && $urandom_range(99) < 15) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_command      <= cmd;
        i_byte_count   <= cnt;
        i_block_handle <= hdl;
        i_block_index  <= idx;
        do @(posedge i_clk); while (busy);
        pred = allocator_step(cmd, cnt, hdl, idx);
        // Typed rows must agree with the predictor too; flag the table if not.
        if (typed && pred !== want) report_mismatch("directed row vs predictor", 0, 1);
        pending_results.push_back(pred);
    endtask

    task automatic issue_checked(logic [1:0] cmd, logic [15:0] cnt,
                                 logic [15:0] hdl, logic [9:0] idx);
        t_alloc_result none;
        none = pack_result(ST_OK, 0, 0, 1'b0);
        issue(cmd, cnt, hdl, idx, 1'b0, none);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Compare every result strobe with the oldest expectation.
    always @(posedge i_clk) begin
        t_alloc_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result strobe", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) report_mismatch("status", o_status, want.status);
                if (o_block_offset !== want.offset)
                    report_mismatch("block_offset", o_block_offset, want.offset);
                if (o_block_size !== want.size)
                    report_mismatch("block_size", o_block_size, want.size);
                if (o_block_free !== want.free)
                    report_mismatch("block_free", o_block_free, want.free);
            end
        end
    end

    // Pick a handle: mostly an existing header, sometimes one byte past a header, sometimes junk.
    function automatic logic [15:0] pick_handle();
        int sel;
        sel = $urandom_range(99);
        if (sel < 10) return 16'($urandom);
        if (sel < 15) return 16'(header_at($urandom_range(blk_count - 1)) + 1);
        return 16'(header_at($urandom_range(blk_count - 1)));
    endfunction

    t_cmd_row directed[$];

    task automatic add_row(logic [1:0] cmd, int cnt, int hdl, int idx, bit typed,
                           logic [2:0] st, int off, int sz, bit fr);
        t_cmd_row r;
        r.cmd = cmd; r.count = 16'(cnt); r.handle = 16'(hdl); r.index = 10'(idx);
        r.typed = typed;
        r.want = pack_result(st, off, sz, fr);
        directed.push_back(r);
    endtask

    initial begin
        logic [1:0]  cmd;
        logic [15:0] cnt;
        int          sel;

        table_clear();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows: reset state, extremes, every error code, exact fit, merges.
        add_row(CMD_QUERY, 0, 0, 0,       1, ST_OK, 0, ARENA - 2 * HDR, 1);
        add_row(CMD_QUERY, 0, 0, 1023,    1, ST_RANGE, 0, 0, 0);
        add_row(CMD_ALLOC, 65535, 0, 0,   1, ST_NO_SPACE, 0, 0, 0);
        add_row(CMD_ALLOC, 100, 0, 0,     1, ST_OK, 0, 100, 0);
        add_row(CMD_ALLOC, 0, 0, 0,       1, ST_OK, 132, 0, 0);
        // Exact fit: leaves a zero-size free remainder.
        add_row(CMD_ALLOC, ARENA - 2 * HDR - 164 - HDR, 0, 0, 0, ST_OK, 0, 0, 0);
        add_row(CMD_QUERY, 0, 0, 3,       0, ST_OK, 0, 0, 0);
        add_row(CMD_ALLOC, 0, 0, 0,       1, ST_NO_SPACE, 0, 0, 0);
        add_row(CMD_FREE, 0, 65535, 0,    1, ST_NOT_START, 0, 0, 0);
        add_row(CMD_FREE, 0, 0, 0,        0, ST_OK, 0, 0, 0);
        add_row(CMD_FREE, 0, 0, 0,        0, ST_OK, 0, 0, 0);
        add_row(CMD_FREE, 0, 132, 0,      0, ST_OK, 0, 0, 0);
        add_row(CMD_FREE, 0, 164, 0,      0, ST_OK, 0, 0, 0);
        add_row(CMD_QUERY, 0, 0, 1,       0, ST_OK, 0, 0, 0);
        add_row(CMD_INIT, 0, 0, 0,        1, ST_OK, 0, ARENA - 2 * HDR, 1);
        add_row(CMD_ALLOC, 10, 0, 0,      0, ST_OK, 0, 0, 0);
        add_row(CMD_ALLOC, 20, 0, 0,      0, ST_OK, 0, 0, 0);
        add_row(CMD_ALLOC, 30, 0, 0,      0, ST_OK, 0, 0, 0);
        add_row(CMD_FREE, 0, 42, 0,       0, ST_OK, 0, 0, 0);
        add_row(CMD_FREE, 0, 0, 0,        0, ST_OK, 0, 0, 0);
        add_row(CMD_ALLOC, 5, 0, 0,       0, ST_OK, 0, 0, 0);
        add_row(CMD_FREE, 0, 94, 0,       0, ST_OK, 0, 0, 0);
        add_row(CMD_QUERY, 0, 0, 2,       0, ST_OK, 0, 0, 0);
        add_row(CMD_INIT, 0, 0, 0,        0, ST_OK, 0, 0, 0);

        foreach (directed[i])
            issue(directed[i].cmd, directed[i].count, directed[i].handle,
                  directed[i].index, directed[i].typed, directed[i].want);

        // Random traffic: mostly live handles and small sizes to build deep tables.
        for (int n = 0; n < RANDOM_OPS; n++) begin
            no_idle = (n >= 200 && n < 320);
            if (n == 100) wait_drained();
            sel = $urandom_range(99);
            cmd = sel < 45 ? CMD_ALLOC : sel < 78 ? CMD_FREE : sel < 98 ? CMD_QUERY : CMD_INIT;
            sel = $urandom_range(99);
            cnt = sel < 70 ? 16'($urandom_range(0, 1500)) :
                  sel < 90 ? 16'($urandom_range(0, 64)) : 16'($urandom);
            issue_checked(cmd, cnt, pick_handle(),
                          $urandom_range(99) < 85 ? 10'($urandom_range(blk_count)) :
                                                    10'($urandom));
        end
        issue_checked(CMD_INIT, 0, 0, 0);

        // Hold until every result is in, then let any trailing activity settle.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("first_fit_block_allocator verification clean");
        end else begin
            $display("first_fit_block_allocator verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #60ms;
        $display("first_fit_block_allocator verification failed");
        $finish;
    end

endmodule

// ===== first_fit_block_allocator.f =====
rtl/ffba_pkg.sv
rtl/ffba_table.sv
rtl/first_fit_block_allocator.sv
sim/first_fit_block_allocator_tb.sv
